// ===== src/utf8cp_pkg.sv =====
`default_nettype none

package utf8cp_pkg;

    localparam int BYTE_W  = 8;
    localparam int CP_W    = 31;
    localparam int REM_W   = 3;
    localparam int CONT_W  = 6;
    localparam int TDATA_W = 32;

    localparam logic [REM_W-1:0] REM_ZERO = REM_W'(0);

    typedef struct packed {
        logic [REM_W-1:0] bytes_remaining;
        logic [CP_W-1:0]  partial_value;
    } t_dec_state;

    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] code_point;
        logic            invalid_lead;
    } t_dec_result;

endpackage

`default_nettype wire

// ===== src/utf8cp_decode.sv =====
`default_nettype none

module utf8cp_decode
    import utf8cp_pkg::*;
(
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire t_dec_state        i_state,
    output t_dec_state             o_state,
    output t_dec_result            o_result
);

    logic [CP_W-1:0]  shifted;
    logic [REM_W-1:0] rem_dec;

    assign shifted = {i_state.partial_value[CP_W-CONT_W-1:0], i_byte[CONT_W-1:0]};
    assign rem_dec = i_state.bytes_remaining - REM_W'(1);

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_state.bytes_remaining != REM_ZERO) begin
            o_state.partial_value   = shifted;
            o_state.bytes_remaining = rem_dec;
            if (rem_dec == REM_ZERO) begin
                o_result.valid        = 1'b1;
                o_result.code_point   = shifted;
                o_state.partial_value = '0;
            end
        end else begin
            case (i_byte) inside
                [8'h00:8'h7F]: begin
                    o_result.valid      = 1'b1;
                    o_result.code_point = CP_W'(i_byte);
                end
                [8'h80:8'hBF]: begin
                    // A stray continuation byte is dropped and leaves the state alone.
                    o_state = i_state;
                end
                [8'hC0:8'hDF]: begin
                    o_state.partial_value   = CP_W'(i_byte[4:0]);
                    o_state.bytes_remaining = REM_W'(1);
                end
                [8'hE0:8'hEF]: begin
                    o_state.partial_value   = CP_W'(i_byte[3:0]);
                    o_state.bytes_remaining = REM_W'(2);
                end
                [8'hF0:8'hF7]: begin
                    o_state.partial_value   = CP_W'(i_byte[2:0]);
                    o_state.bytes_remaining = REM_W'(3);
                end
                [8'hF8:8'hFB]: begin
                    o_state.partial_value   = CP_W'(i_byte[1:0]);
                    o_state.bytes_remaining = REM_W'(4);
                end
                [8'hFC:8'hFD]: begin
                    o_state.partial_value   = CP_W'(i_byte[0]);
                    o_state.bytes_remaining = REM_W'(5);
                end
                default: begin
                    o_state.partial_value = '0;
                    o_result.valid        = 1'b1;
                    o_result.invalid_lead = 1'b1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/utf8_to_code_point_decoder.sv =====
// UTF-8 to code point decoder.
// One byte enters per transaction on the slave channel (s_axis_*), one code
// point leaves per transaction on the master channel (m_axis_*). Legacy 5- and
// 6-byte sequences are decoded to 31-bit code points. Lead bytes 0xFE and 0xFF
// give a result with code point zero and the invalid flag in tuser set; stray
// continuation bytes give no result.
// A byte is held in an input register, decoded combinationally against the
// sequence state and written into the output register. A result is offered once
// the byte that completes its sequence has passed through the input register
// and then the output register. Throughput is one byte per cycle while results
// are taken; the input register and output register form a two-stage pipeline
// in which the decode step advances whenever the output register is empty or
// being emptied.
// When the receiver stalls, the result is held, the input register fills and
// s_axis_tready then falls until the result is taken.
// Synchronous reset empties both registers and returns the decoder to its idle
// state, discarding any partial sequence.
`default_nettype none

module utf8_to_code_point_decoder
    import utf8cp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [BYTE_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata,   // [30:0] code_point, [31] zero
    output logic                    m_axis_tuser    // [0] invalid_lead
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    t_dec_state        r_state;
    t_dec_state        n_state;
    t_dec_result       dec_result;
    logic              r_out_valid;
    logic [CP_W-1:0]   r_out_cp;
    logic              r_out_invalid;
    logic              advance;
    logic              out_free;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || advance;

    utf8cp_decode u_decode (
        .i_byte   (r_in_byte),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (dec_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && dec_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && dec_result.valid) begin
            r_out_cp      <= dec_result.code_point;
            r_out_invalid <= dec_result.invalid_lead;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out_cp);
    assign m_axis_tuser  = r_out_invalid;

endmodule

`default_nettype wire

// ===== tb/sv/utf8_to_code_point_decoder_tb.sv =====
module utf8_to_code_point_decoder_tb;
    import utf8cp_pkg::*;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            invalid_lead;
    } t_decoded_char;

    localparam int PHASE_BYTES = 400;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [BYTE_W-1:0]      s_axis_tdata = '0;   // [7:0] data_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]     m_axis_tdata;        // [30:0] code_point, [31] zero
    logic                   m_axis_tuser;        // [0] invalid_lead

    logic [BYTE_W-1:0]      byte_queue[$];
    t_decoded_char          expected_chars[$];

    logic [REM_W-1:0]       cont_left = '0;
    logic [CP_W-1:0]        gathered_bits = '0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int error_count = 0;
    int bytes_accepted = 0;
    int chars_checked = 0;
    int invalid_seen = 0;

    utf8_to_code_point_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Advances the sequence state by one byte; returns 1 when a character is complete.
    function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output t_decoded_char ch);
        ch = '0;
        if (cont_left != REM_ZERO) begin
            gathered_bits = {gathered_bits[CP_W-CONT_W-1:0], b[CONT_W-1:0]};
            cont_left = cont_left - 1'b1;
            if (cont_left == REM_ZERO) begin
                ch.code_point = gathered_bits;
                gathered_bits = '0;
                return 1'b1;
            end
            return 1'b0;
        end
        casez (b)
            8'b0???????: begin
                ch.code_point = CP_W'(b);
                return 1'b1;
            end
            8'b110?????: begin
                gathered_bits = CP_W'(b[4:0]);
                cont_left = 3'd1;
            end
            8'b1110????: begin
                gathered_bits = CP_W'(b[3:0]);
                cont_left = 3'd2;
            end
            8'b11110???: begin
                gathered_bits = CP_W'(b[2:0]);
                cont_left = 3'd3;
            end
            8'b111110??: begin
                gathered_bits = CP_W'(b[1:0]);
                cont_left = 3'd4;
            end
            8'b1111110?: begin
                gathered_bits = CP_W'(b[0]);
                cont_left = 3'd5;
            end
            8'b1111111?: begin
                gathered_bits = '0;
                ch.invalid_lead = 1'b1;
                return 1'b1;
            end
            default: begin
            end
        endcase
        return 1'b0;
    endfunction

    task automatic push_random_run(input int byte_count);
        int pushed;
        int pick;
        int seq_len;
        logic [BYTE_W-1:0] lead;
        pushed = 0;
        while (pushed < byte_count) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                byte_queue.push_back(BYTE_W'($urandom_range(0, 255)));
                pushed++;
            end else if (pick < 14) begin
                byte_queue.push_back({7'b1111111, 1'($urandom_range(0, 1))});
                pushed++;
            end else begin
                seq_len = $urandom_range(1, 6);
                lead = BYTE_W'($urandom_range(0, 255));
                case (seq_len)
                    1: lead[7] = 1'b0;
                    2: lead[7:5] = 3'b110;
                    3: lead[7:4] = 4'b1110;
                    4: lead[7:3] = 5'b11110;
                    5: lead[7:2] = 6'b111110;
                    default: lead[7:1] = 7'b1111110;
                endcase
                byte_queue.push_back(lead);
                pushed++;
                for (int k = 1; k < seq_len; k++) begin
                    if ($urandom_range(0, 99) < 8)
                        byte_queue.push_back(BYTE_W'($urandom_range(0, 255)));
                    else
                        byte_queue.push_back({2'b10, 6'($urandom_range(0, 63))});
                    pushed++;
                end
            end
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall, input int byte_count);
        send_idle_pct = idle_pct;
        stall_pct = stall;
        push_random_run(byte_count);
        while (byte_queue.size() != 0)
            @(negedge i_clk);
    endtask

    // A transaction on the slave side feeds the predictor before the next byte is offered.
    always @(posedge i_clk) begin
        t_decoded_char ch;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                bytes_accepted++;
                if (decode_byte(s_axis_tdata, ch))
                    expected_chars.push_back(ch);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= byte_queue.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_decoded_char want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected result code_point %h invalid_lead %b",
                         $time, m_axis_tdata[CP_W-1:0], m_axis_tuser);
                error_count++;
            end else begin
                want = expected_chars.pop_front();
                chars_checked++;
                if (want.invalid_lead)
                    invalid_seen++;
                if (m_axis_tdata[CP_W-1:0] !== want.code_point) begin
                    $display("%0t: code_point mismatch, expected %h actual %h",
                             $time, want.code_point, m_axis_tdata[CP_W-1:0]);
                    error_count++;
                end
                if (m_axis_tuser !== want.invalid_lead) begin
                    $display("%0t: invalid_lead mismatch, expected %b actual %b",
                             $time, want.invalid_lead, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[TDATA_W-1] !== 1'b0) begin
                    $display("%0t: tdata padding mismatch, expected 0 actual %b",
                             $time, m_axis_tdata[TDATA_W-1]);
                    error_count++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [BYTE_W-1:0] directed[$];
        directed = '{8'h00, 8'h7F, 8'hDF, 8'hBF, 8'hC3, 8'h41,
                     8'hEF, 8'hBF, 8'hBF, 8'hF7, 8'hBF, 8'hBF, 8'hBF,
                     8'hFB, 8'h80, 8'h80, 8'h80, 8'h80,
                     8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
                     8'hFE, 8'hFF, 8'h80};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed[k])
            byte_queue.push_back(directed[k]);
        run_phase(0, 0, PHASE_BYTES - directed.size());
        run_phase(55, 0, PHASE_BYTES);
        run_phase(0, 55, PHASE_BYTES);
        run_phase(15, 15, PHASE_BYTES);
        // The stream ends part-way through a four-byte sequence, which must produce nothing.
        byte_queue.push_back(8'hF0);
        byte_queue.push_back(8'h90);
        while (byte_queue.size() != 0 || s_axis_tvalid)
            @(negedge i_clk);
        while (expected_chars.size() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (expected_chars.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_chars.size());
            error_count++;
        end
        $display("Run covered %0d bytes and %0d decoded characters, %0d of them invalid leads,",
                 bytes_accepted, chars_checked, invalid_seen);
        $display("across one- to six-byte sequences, stray and malformed bytes and four idling mixes.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/utf8cp_pkg.sv
src/utf8cp_decode.sv
src/utf8_to_code_point_decoder.sv
tb/sv/utf8_to_code_point_decoder_tb.sv
